@@ rtl/dhc_pkg.sv @@
`default_nettype none

package dhc_pkg;

  // Field and register widths.
  localparam int unsigned DispW  = 8;
  localparam int unsigned SatW   = 9;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // The hue divider retires one quotient bit per stage.
  localparam int unsigned DivSteps = DispW;
  localparam int unsigned NumW     = 2 * DispW;

  // Register stages inside one channel unit.
  localparam int unsigned ChanLat = 3;

  // Hue span and sector width in degrees.
  localparam logic [7:0] HueSpan     = 8'd240;
  localparam logic [7:0] SectorWidth = 8'd60;

  // One HSV term in units of 1/(256*60): values span about -15300 .. 15360.
  localparam int unsigned TermW = 17;
  typedef logic signed [TermW-1:0] term_t;
  localparam term_t TermOne = 17'sd15360;

  // Common denominator 256 * 256 * 60 and its half, for round-half-up.
  localparam logic [21:0] DenQ    = 22'd3932160;
  localparam logic [21:0] HalfDen = 22'd1966080;

  // ceil(2^20 / 60): exact division by 60 for all values below 15360.
  localparam logic [14:0] RecipSixty = 15'd17477;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxDisp    = 2'd0,
    CfgSaturation = 2'd1,
    CfgBrightness = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ rtl/dhc_hue_div.sv @@
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage.
// The quotient is known to fit in DivSteps bits, so the remainder starts
// from the upper half of the numerator.
module dhc_hue_div (
  input  logic                         clk_i,
  input  logic [dhc_pkg::NumW-1:0]     num_i,
  input  logic [dhc_pkg::DispW-1:0]    den_i,
  output logic [dhc_pkg::DivSteps-1:0] quo_o
);
  import dhc_pkg::*;

  logic [DispW-1:0]    rem_s [DivSteps];
  logic [DispW-1:0]    low_s [DivSteps];
  logic [DivSteps-1:0] quo_s [DivSteps+1];

  assign rem_s[0] = num_i[NumW-1:DispW];
  assign low_s[0] = num_i[DispW-1:0];
  assign quo_s[0] = '0;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [DispW:0] trial;
    logic [DispW:0] diff;
    logic           ge;

    always_comb begin
      trial = {rem_s[i], low_s[i][DispW-1]};
      diff  = trial - {1'b0, den_i};
      ge    = (trial >= {1'b0, den_i});
    end

    always_ff @(posedge clk_i) begin
      quo_s[i+1] <= {quo_s[i][DivSteps-2:0], ge};
    end

    if (i < DivSteps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_s[i+1] <= ge ? diff[DispW-1:0] : trial[DispW-1:0];
        low_s[i+1] <= {low_s[i][DispW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_s[DivSteps];

endmodule

`default_nettype wire

@@ rtl/dhc_channel.sv @@
`default_nettype none

// One color channel: scale the term by brightness, clamp to [0, 1],
// then round(255 * x) with an exact reciprocal division by 60.
module dhc_channel (
  input  logic                      clk_i,
  input  dhc_pkg::term_t            term_i,
  input  logic [dhc_pkg::SatW-1:0]  value_i,
  output logic [dhc_pkg::ChanW-1:0] chan_o
);
  import dhc_pkg::*;

  localparam int unsigned ProdW = TermW + SatW + 1;

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic [21:0]             clamped;
  logic [29:0]             scaled;
  logic [13:0]             coarse_d, coarse_q;
  logic [28:0]             recip;
  logic [ChanW-1:0]        chan_d, chan_q;

  // Stage 1: brightness times term.
  assign prod_d = ProdW'($signed({1'b0, value_i})) * ProdW'(term_i);

  // Stage 2: clamp, scale by 255, add half, drop the power-of-two part.
  always_comb begin
    if (prod_q[ProdW-1]) begin
      clamped = '0;
    end else if (prod_q[ProdW-2:0] > (ProdW-1)'(DenQ)) begin
      clamped = DenQ;
    end else begin
      clamped = prod_q[21:0];
    end
    scaled   = (30'(clamped) << 8) - 30'(clamped) + 30'(HalfDen);
    coarse_d = scaled[29:16];
  end

  // Stage 3: divide by 60.
  always_comb begin
    recip  = 29'(coarse_q) * 29'(RecipSixty);
    chan_d = recip[27:20];
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    coarse_q <= coarse_d;
    chan_q   <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

@@ rtl/disparity_to_hsv_color_unit.sv @@
// done_o rises together with the result, once the item has passed the input stage, the
// divider stages, the sector stage and the channel stages.
// Throughput: one item per clock; busy_o stays low, so start_i may be held high.
// The result is shown for one cycle only; the receiver cannot stall the pipeline.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads max_disparity 255,
// saturation 256 and brightness 256.
`default_nettype none

module disparity_to_hsv_color_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [dhc_pkg::DispW-1:0]   disparity_i,
  output logic                        done_o,
  output logic [dhc_pkg::ChanW-1:0]   blue_o,
  output logic [dhc_pkg::ChanW-1:0]   green_o,
  output logic [dhc_pkg::ChanW-1:0]   red_o,
  input  logic                        cfg_we_i,
  input  logic [dhc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dhc_pkg::SatW-1:0]    cfg_data_i
);
  import dhc_pkg::*;

  // Pipeline: one input stage that forms the hue numerator, DivSteps divider
  // stages, one stage that picks the sector and the HSV terms, and the
  // channel units. A valid bit travels alongside the whole depth.
  localparam int unsigned Latency = 1 + DivSteps + 1 + ChanLat;

  localparam logic [7:0] Bound1 = 8'(1 * SectorWidth);
  localparam logic [7:0] Bound2 = 8'(2 * SectorWidth);
  localparam logic [7:0] Bound3 = 8'(3 * SectorWidth);
  localparam logic [7:0] Bound4 = 8'(4 * SectorWidth);

  typedef enum logic [2:0] {
    SecRed    = 3'd0,
    SecYellow = 3'd1,
    SecGreen  = 3'd2,
    SecCyan   = 3'd3,
    SecBlue   = 3'd4
  } sector_e;

  // Configuration registers. The user must change them only while the pipeline
  // is empty (the block does not enforce it), so every stage reads them directly.
  logic [DispW-1:0] max_q;
  logic [SatW-1:0]  sat_q;
  logic [SatW-1:0]  bri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 8'd255;
      sat_q <= 9'd256;
      bri_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMaxDisp:    max_q <= cfg_data_i[DispW-1:0];
        CfgSaturation: sat_q <= cfg_data_i;
        CfgBrightness: bri_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // Valid bits for every stage; the last one is the result strobe.
  logic [Latency-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], accept};
    end
  end

  assign done_o = vld_q[Latency-1];

  // Input stage: numerator (max - d) * 240. A disparity at or above the maximum
  // gives a zero numerator and hue zero; a zero maximum also zeroes it.
  logic [DispW-1:0] span;
  logic [NumW-1:0]  num_d, num_q;

  always_comb begin
    span  = (disparity_i < max_q) ? (max_q - disparity_i) : '0;
    num_d = NumW'(span) * NumW'(HueSpan);
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  // Hue = numerator / max, one bit per stage.
  logic [DivSteps-1:0] hue;

  dhc_hue_div u_hue_div (
    .clk_i (clk_i),
    .num_i (num_q),
    .den_i (max_q),
    .quo_o (hue)
  );

  // Sector stage: split the hue into sector and remainder, build the
  // p, q and t terms in units of 1/(256*60), and route them per channel.
  sector_e     sector;
  logic [5:0]  frac;
  logic [14:0] frac_sat;
  term_t       sat60;
  term_t       term_v, term_p, term_q, term_t_;
  term_t       blue_d, green_d, red_d;
  term_t       blue_q, green_q, red_q;

  always_comb begin
    if (hue >= Bound4) begin
      sector = SecBlue;
      frac   = 6'(hue - Bound4);
    end else if (hue >= Bound3) begin
      sector = SecCyan;
      frac   = 6'(hue - Bound3);
    end else if (hue >= Bound2) begin
      sector = SecGreen;
      frac   = 6'(hue - Bound2);
    end else if (hue >= Bound1) begin
      sector = SecYellow;
      frac   = 6'(hue - Bound1);
    end else begin
      sector = SecRed;
      frac   = hue[5:0];
    end

    frac_sat = 15'(frac) * 15'(sat_q);
    sat60    = term_t'((TermW'(sat_q) << 6) - (TermW'(sat_q) << 2));

    term_v  = TermOne;
    term_p  = TermOne - sat60;
    term_q  = TermOne - term_t'(frac_sat);
    term_t_ = TermOne - sat60 + term_t'(frac_sat);

    case (sector)
      SecRed: begin
        blue_d = term_p; green_d = term_t_; red_d = term_v;
      end
      SecYellow: begin
        blue_d = term_p; green_d = term_v; red_d = term_q;
      end
      SecGreen: begin
        blue_d = term_t_; green_d = term_v; red_d = term_p;
      end
      SecCyan: begin
        blue_d = term_v; green_d = term_q; red_d = term_p;
      end
      default: begin
        blue_d = term_v; green_d = term_p; red_d = term_t_;
      end
    endcase

    // A zero maximum gives black: zero terms round to zero.
    if (max_q == '0) begin
      blue_d  = '0;
      green_d = '0;
      red_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    blue_q  <= blue_d;
    green_q <= green_d;
    red_q   <= red_d;
  end

  // Channel units: scale by brightness, clamp and round to 8 bits.
  dhc_channel u_blue (
    .clk_i   (clk_i),
    .term_i  (blue_q),
    .value_i (bri_q),
    .chan_o  (blue_o)
  );

  dhc_channel u_green (
    .clk_i   (clk_i),
    .term_i  (green_q),
    .value_i (bri_q),
    .chan_o  (green_o)
  );

  dhc_channel u_red (
    .clk_i   (clk_i),
    .term_i  (red_q),
    .value_i (bri_q),
    .chan_o  (red_o)
  );

endmodule

`default_nettype wire

@@ dv/disparity_to_hsv_color_unit_tb.sv @@
`timescale 1ns / 1ps

module disparity_to_hsv_color_unit_tb;
  import dhc_pkg::*;

  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  // Fixed-point constants of the color math, in units of 1/(256*256*60).
  localparam longint QOne     = 256;
  localparam longint LevelMax = 255;
  localparam longint ColorDen = QOne * QOne * longint'(SectorWidth);

  // A result is taken this many edges after the edge that accepts its item.
  localparam int ResultLat  = 13;
  localparam int NumPhases  = 11;
  localparam int PhaseItems = 50;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  // One row of the directed table: the register setting it needs, the pixel, and,
  // where the answer is obvious, the color typed in by hand.
  typedef struct {
    logic [DispW-1:0] max_disp;
    logic [SatW-1:0]  sat;
    logic [SatW-1:0]  bri;
    logic [DispW-1:0] disp;
    bit               typed;
    pixel_t           px;
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic [DispW-1:0]   disparity_i = '0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = CfgMaxDisp;
  logic [SatW-1:0]    cfg_data_i  = '0;
  logic               busy_o;
  logic               done_o;
  logic [ChanW-1:0]   blue_o;
  logic [ChanW-1:0]   green_o;
  logic [ChanW-1:0]   red_o;

  // Side band that travels with each item: when set, the monitor takes the
  // hand-typed color instead of asking the color predictor.
  logic   typed_hint = 1'b0;
  pixel_t typed_px   = '0;

  // Shadow copy of the three registers, as the block should hold them.
  logic [DispW-1:0] max_disp_m = 8'd255;
  logic [SatW-1:0]  sat_m      = 9'd256;
  logic [SatW-1:0]  bri_m      = 9'd256;

  // Colors still owed by the block, oldest first.
  pixel_t    pending_px[$];
  stim_row_t directed[$];

  int err_cnt      = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;

  disparity_to_hsv_color_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .disparity_i (disparity_i),
    .done_o      (done_o),
    .blue_o      (blue_o),
    .green_o     (green_o),
    .red_o       (red_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Clamp one numerator to [0, ColorDen] and scale it to 0..255, halves rounded up.
  function automatic logic [ChanW-1:0] to_level(longint num);
    longint n;
    n = num;
    if (n < 0) n = 0;
    if (n > ColorDen) n = ColorDen;
    return ChanW'((n * LevelMax + ColorDen / 2) / ColorDen);
  endfunction

  // Color predictor: HSV to BGR for one disparity pixel under the shadow registers.
  function automatic pixel_t paint_pixel(logic [DispW-1:0] d);
    longint mx, dd, hue, sect, rem, s, v, nv, np, nq, nt;
    longint span, width;
    pixel_t px;
    span  = longint'(HueSpan);
    width = longint'(SectorWidth);
    mx    = longint'(max_disp_m);
    dd    = longint'(d);
    // A zero maximum turns every pixel black.
    if (mx == 0) return '0;
    // Pixels at or beyond the maximum all land on hue zero.
    hue  = (dd >= mx) ? 0 : ((mx - dd) * span) / mx;
    sect = hue / width;
    rem  = hue % width;
    s    = longint'(sat_m);
    v    = longint'(bri_m);
    nv   = v * QOne * width;
    np   = v * (QOne - s) * width;
    nq   = v * (QOne * width - rem * s);
    nt   = v * (QOne * width - (width - rem) * s);
    case (sect)
      0: px = '{blue: to_level(np), green: to_level(nt), red: to_level(nv)};
      1: px = '{blue: to_level(np), green: to_level(nv), red: to_level(nq)};
      2: px = '{blue: to_level(nt), green: to_level(nv), red: to_level(np)};
      3: px = '{blue: to_level(nv), green: to_level(nq), red: to_level(np)};
      default: px = '{blue: to_level(nv), green: to_level(np), red: to_level(nt)};
    endcase
    return px;
  endfunction

  function automatic void check_chan(string name, logic [ChanW-1:0] want,
                                     logic [ChanW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // The monitor samples at the rising edge, so it sees the values that the edge
  // itself acts on. Results are compared first, then a newly accepted item adds
  // its color to the back of the queue.
  always @(posedge clk_i) begin : watch
    pixel_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_px.size() == 0) begin
          $error("result with no item pending: blue %0d green %0d red %0d",
                 blue_o, green_o, red_o);
          err_cnt++;
        end else begin
          want = pending_px.pop_front();
          check_chan("blue", want.blue, blue_o);
          check_chan("green", want.green, green_o);
          check_chan("red", want.red, red_o);
          results_seen++;
        end
      end
      if (start_i && !busy_o) begin
        pending_px.push_back(typed_hint ? typed_px : paint_pixel(disparity_i));
      end
    end
  end

  // Offers one item, after a random number of idle cycles, and returns at the
  // edge that takes it. start_i is left high, so back-to-back items need no gap.
  task automatic send_pixel(input logic [DispW-1:0] d, input int idle_pct,
                            input bit typed, input pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      start_i     <= 1'b0;
      disparity_i <= DispW'($urandom);
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    disparity_i <= d;
    typed_hint  <= typed;
    typed_px    <= px;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // Stops offering items and waits until every owed color has come back. Every
  // item yields a result, so an empty queue means the pipeline is empty too.
  task automatic drain_pipe();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_px.size() != 0);
  endtask

  // The write enable is left high here; the caller lowers it once after the last
  // write, so back-to-back writes never assign it twice in one step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SatW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgMaxDisp:    max_disp_m = val[DispW-1:0];
      CfgSaturation: sat_m = val;
      CfgBrightness: bri_m = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Loads a full register setting while the block is idle. The top bit of the
  // data port is random for the 8-bit max register, which must drop it.
  task automatic apply_setting(input logic [DispW-1:0] m, input logic [SatW-1:0] s,
                               input logic [SatW-1:0] b, input bit spare);
    drain_pipe();
    write_reg(CfgMaxDisp, {1'($urandom_range(1)), m});
    write_reg(CfgSaturation, s);
    write_reg(CfgBrightness, b);
    if (spare) write_reg(CfgSpare, SatW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_row(logic [DispW-1:0] m, logic [SatW-1:0] s,
                                  logic [SatW-1:0] b, logic [DispW-1:0] d, bit typed,
                                  logic [ChanW-1:0] bl, logic [ChanW-1:0] gr,
                                  logic [ChanW-1:0] rd);
    stim_row_t row;
    row.max_disp = m;
    row.sat      = s;
    row.bri      = b;
    row.disp     = d;
    row.typed    = typed;
    row.px       = '{blue: bl, green: gr, red: rd};
    directed.push_back(row);
  endfunction

  // Register values lean toward the extremes and full scale.
  function automatic logic [SatW-1:0] pick_level(int unsigned hi);
    case ($urandom_range(7))
      0: return '0;
      1: return SatW'(hi);
      2: return (hi > 256) ? 9'd256 : 9'd1;
      default: return SatW'($urandom_range(hi));
    endcase
  endfunction

  // Most pixels are uniform; some sit right around the maximum, where the hue
  // saturates and the sector boundaries are tight.
  function automatic logic [DispW-1:0] pick_disp();
    int d;
    if ($urandom_range(9) < 3) begin
      d = int'(max_disp_m) + int'($urandom_range(4)) - 2;
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      return DispW'(d);
    end
    return DispW'($urandom_range(255));
  endfunction

  initial begin : stimulus
    int idle_plan[3];
    int n_directed;
    idle_plan = '{0, 70, 34};

    // Directed table. Typed rows are the cases whose color is plain: pure blue
    // at disparity zero, pure red at or beyond the maximum, black for a zero
    // maximum or zero brightness, white for zero saturation, and clamping when
    // a register exceeds 1.0. The remaining rows walk the five sectors.
    add_row(8'd255, 9'd256, 9'd256, 8'd0,   1, 8'd255, 8'd0,   8'd0);
    add_row(8'd255, 9'd256, 9'd256, 8'd255, 1, 8'd0,   8'd0,   8'd255);
    add_row(8'd255, 9'd256, 9'd256, 8'd200, 0, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd256, 9'd256, 8'd170, 0, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd256, 9'd256, 8'd100, 0, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd256, 9'd256, 8'd50,  0, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd256, 9'd256, 8'd10,  0, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd256, 9'd256, 8'd128, 0, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd256, 9'd256, 8'd1,   0, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd256, 9'd256, 8'd254, 0, 8'd0,   8'd0,   8'd0);
    add_row(8'd100, 9'd256, 9'd256, 8'd200, 1, 8'd0,   8'd0,   8'd255);
    add_row(8'd100, 9'd256, 9'd256, 8'd100, 1, 8'd0,   8'd0,   8'd255);
    add_row(8'd100, 9'd256, 9'd256, 8'd37,  0, 8'd0,   8'd0,   8'd0);
    add_row(8'd0,   9'd256, 9'd256, 8'd0,   1, 8'd0,   8'd0,   8'd0);
    add_row(8'd0,   9'd256, 9'd256, 8'd255, 1, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd0,   9'd256, 8'd77,  1, 8'd255, 8'd255, 8'd255);
    add_row(8'd255, 9'd256, 9'd0,   8'd77,  1, 8'd0,   8'd0,   8'd0);
    add_row(8'd255, 9'd0,   9'd511, 8'd200, 1, 8'd255, 8'd255, 8'd255);
    add_row(8'd255, 9'd511, 9'd256, 8'd255, 1, 8'd0,   8'd0,   8'd255);
    add_row(8'd255, 9'd511, 9'd511, 8'd90,  0, 8'd0,   8'd0,   8'd0);
    add_row(8'd1,   9'd128, 9'd200, 8'd0,   0, 8'd0,   8'd0,   8'd0);
    add_row(8'd1,   9'd256, 9'd256, 8'd1,   1, 8'd0,   8'd0,   8'd255);
    add_row(8'd255, 9'd128, 9'd384, 8'd60,  0, 8'd0,   8'd0,   8'd0);

    // Reset is held low from time zero and released on a rising edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first rows run under the reset values, so no write precedes them.
    foreach (directed[i]) begin
      if (directed[i].max_disp != max_disp_m || directed[i].sat != sat_m ||
          directed[i].bri != bri_m) begin
        apply_setting(directed[i].max_disp, directed[i].sat, directed[i].bri, 0);
      end
      send_pixel(directed[i].disp, 0, directed[i].typed, directed[i].px);
    end
    n_directed = items_sent;

    // Random phases: a fresh register setting each time, the first few pinned
    // to the extremes, and the sender's idling cycled through none, heavy and
    // moderate.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: apply_setting(8'd255, 9'd511, 9'd511, 1);
        1: apply_setting(8'd0, 9'd0, 9'd0, 0);
        2: apply_setting(8'd1, 9'd256, 9'd256, 0);
        default: apply_setting(DispW'(pick_level(255)), pick_level(511), pick_level(511),
                               ph % 3 == 0);
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        send_pixel(pick_disp(), idle_plan[ph % 3], 0, '0);
      end
    end

    // Let every owed color arrive, then watch a while longer for strays.
    drain_pipe();
    repeat (2 * ResultLat) @(posedge clk_i);

    $display("Sent %0d items (%0d from the directed table) under %0d register writes;",
             items_sent, n_directed, cfg_writes);
    $display("checked %0d colors, %0d mismatches.", results_seen, err_cnt);
    if (err_cnt == 0 && pending_px.size() == 0) begin
      $display("disparity_to_hsv_color_unit_tb: PASS");
    end else begin
      if (pending_px.size() != 0) begin
        $error("%0d colors never arrived", pending_px.size());
      end
      $display("disparity_to_hsv_color_unit_tb: FAIL");
    end
    $finish;
  end

  // Safety net: ends a run that hangs with a failure.
  initial begin : watchdog
    #2_000_000;
    $display("disparity_to_hsv_color_unit_tb: FAIL");
    $finish;
  end

endmodule
